[rtl/read_completion_reorder_buffer_assert.svh]
// Assertion macros for the read completion reorder buffer.
// Expects signals named clk and rst_n in the including module's scope.
`ifndef READ_COMPLETION_REORDER_BUFFER_ASSERT_SVH
`define READ_COMPLETION_REORDER_BUFFER_ASSERT_SVH

// expression holds on every edge out of reset
`define RCRB_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequence holds on the edge after the antecedent
`define RCRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define RCRB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/rcrb_pkg.sv]
// Shared types and constants of the read completion reorder buffer.
// No dependencies; used by rcrb_cell and read_completion_reorder_buffer.
package rcrb_pkg;

    localparam int SEQ_W    = 32;
    localparam int TAG_W    = 8;
    localparam int LEN_W    = 13;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ISSUED    = 3'd0,
        STAT_DELIVERED = 3'd1,
        STAT_HELD      = 3'd2,
        STAT_DROPPED   = 3'd3,
        STAT_CLOSED    = 3'd4,
        STAT_DISCARDED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN,
        S_CLOSE
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
    } entry_t;

    typedef struct packed {
        logic   occ;
        entry_t entry;
    } slot_t;

    // prefix flags rippling from cell 0 upward
    typedef struct packed {
        logic ins_hit;
        logic rm_hit;
    } chain_t;

endpackage

[rtl/rcrb_cell.sv]
// One store cell of the reorder buffer: an entry, its occupied flag, and the
// local insert / match decisions. Depends on rcrb_pkg.
module rcrb_cell
    import rcrb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_op_t         op,
    input  logic [SEQ_W-1:0] exp_seq,
    input  logic [SEQ_W-1:0] in_dist,
    input  entry_t           ins_entry,
    input  slot_t            left,
    input  slot_t            right,
    input  chain_t           chain_in,
    output slot_t            slot,
    output chain_t           chain_out,
    output logic             sel
);

    entry_t           entry_reg;
    entry_t           entry_next;
    logic             occ_reg;
    logic             occ_next;
    logic [SEQ_W-1:0] own_dist;
    logic             ins_hit;
    logic             rm_hit;

    assign own_dist = entry_reg.seq - exp_seq;
    assign ins_hit  = !occ_reg || (in_dist < own_dist);
    assign rm_hit   = occ_reg && (entry_reg.seq == exp_seq);

    assign chain_out.ins_hit = chain_in.ins_hit | ins_hit;
    assign chain_out.rm_hit  = chain_in.rm_hit | rm_hit;
    assign sel               = rm_hit && !chain_in.rm_hit;

    assign slot.occ   = occ_reg;
    assign slot.entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        occ_next   = occ_reg;
        case (op)
            CELL_INSERT:
            begin
                if (chain_in.ins_hit)
                begin
                    entry_next = left.entry;
                    occ_next   = left.occ;
                end
                else if (ins_hit)
                begin
                    entry_next = ins_entry;
                    occ_next   = 1'b1;
                end
            end
            CELL_REMOVE:
            begin
                if (chain_in.rm_hit || rm_hit)
                begin
                    entry_next = right.entry;
                    occ_next   = right.occ;
                end
            end
            CELL_POP:
            begin
                entry_next = right.entry;
                occ_next   = right.occ;
            end
            default:
            begin
                entry_next = entry_reg;
                occ_next   = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[rtl/read_completion_reorder_buffer.sv]
// Top level of the read completion reorder buffer: control, counters, result
// register and the row of rcrb_cell stages. Depends on rcrb_pkg and the assert header.
//
// channel  handshake             payload
// req      req_valid/req_stall   action, seq, buffer_tag, byte_count
// rsp      rsp_valid/rsp_stall   status, out_seq, out_tag, out_count, last
//
// Issue, held and dropped: the request is captured in idle, then exec gives one result.
// Delivery: exec, then drain gives the delivery and the k held entries released behind it.
// Close: each of the n held entries is discarded in turn, then a closed result.
// One result per cycle into the single result register; a stalled rsp pauses the sequence.
// Reset clears counters, occupancy and control; held entries need no clearing.
module read_completion_reorder_buffer
    import rcrb_pkg::*;
#(
    parameter int DEPTH     = 8,
    parameter int MAX_BYTES = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic             action,
    input  logic [SEQ_W-1:0] seq,
    input  logic [TAG_W-1:0] buffer_tag,
    input  logic [LEN_W-1:0] byte_count,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output logic [2:0]       status,
    output logic [SEQ_W-1:0] out_seq,
    output logic [TAG_W-1:0] out_tag,
    output logic [LEN_W-1:0] out_count,
    output logic             last
);

`include "read_completion_reorder_buffer_assert.svh"

    localparam int CAP_W = LEN_W + 4;
    localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(MAX_BYTES);

    state_t           state_reg;
    state_t           state_next;
    logic [SEQ_W-1:0] issue_seq_reg;
    logic [SEQ_W-1:0] issue_seq_next;
    logic [SEQ_W-1:0] exp_reg;
    logic [SEQ_W-1:0] exp_next;
    logic             in_action_reg;
    logic             in_action_next;
    entry_t           in_entry_reg;
    entry_t           in_entry_next;
    entry_t           pend_reg;
    entry_t           pend_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    status_t          rsp_status_reg;
    entry_t           rsp_entry_reg;
    logic             rsp_last_reg;

    logic             slot_free;
    logic             rsp_load;
    status_t          res_status;
    entry_t           res_entry;
    logic             res_last;
    cell_op_t         cell_op;
    logic [LEN_W-1:0] cnt_sat;
    logic [SEQ_W-1:0] in_dist;
    logic             is_close;
    logic             is_deliver;
    logic             full;
    logic             found;
    entry_t           found_entry;

    slot_t            cell_slot  [DEPTH];
    slot_t            left_slot  [DEPTH];
    slot_t            right_slot [DEPTH];
    chain_t           chain_in   [DEPTH];
    chain_t           chain_out  [DEPTH];
    logic [DEPTH-1:0] sel_vec;
    logic [DEPTH-1:0] occ_vec;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign left_slot[gi] = '{occ: 1'b1, entry: '0};
                assign chain_in[gi]  = '0;
            end
            else
            begin : g_body
                assign left_slot[gi] = cell_slot[gi-1];
                assign chain_in[gi]  = chain_out[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_slot[gi] = '0;
            end
            else
            begin : g_mid
                assign right_slot[gi] = cell_slot[gi+1];
            end

            rcrb_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (cell_op),
                .exp_seq   (exp_reg),
                .in_dist   (in_dist),
                .ins_entry (in_entry_reg),
                .left      (left_slot[gi]),
                .right     (right_slot[gi]),
                .chain_in  (chain_in[gi]),
                .slot      (cell_slot[gi]),
                .chain_out (chain_out[gi]),
                .sel       (sel_vec[gi])
            );

            assign occ_vec[gi] = cell_slot[gi].occ;
        end
    endgenerate

    assign cnt_sat    = (CAP_W'(byte_count) > MAX_CAP) ? MAX_CAP[LEN_W-1:0] : byte_count;
    assign in_dist    = in_entry_reg.seq - exp_reg;
    assign is_close   = (in_entry_reg.len == '0);
    assign is_deliver = (in_entry_reg.seq == exp_reg);
    assign full       = occ_vec[DEPTH-1];
    assign found      = chain_out[DEPTH-1].rm_hit;
    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        found_entry = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel_vec[i])
            begin
                found_entry = entry_t'(found_entry | cell_slot[i].entry);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (in_action_reg && is_close)
                begin
                    state_next = S_CLOSE;
                end
                else if (in_action_reg && is_deliver)
                begin
                    state_next = S_DRAIN;
                end
                else if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (slot_free && !found)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLOSE:
            begin
                if (slot_free && !occ_vec[0])
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        issue_seq_next = issue_seq_reg;
        exp_next       = exp_reg;
        in_action_next = in_action_reg;
        in_entry_next  = in_entry_reg;
        pend_next      = pend_reg;
        rsp_load       = 1'b0;
        res_status     = STAT_ISSUED;
        res_entry      = in_entry_reg;
        res_last       = 1'b1;
        cell_op        = CELL_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    in_action_next = action;
                    in_entry_next  = '{seq: seq, tag: buffer_tag, len: cnt_sat};
                end
            end
            S_EXEC:
            begin
                if (!in_action_reg)
                begin
                    res_status = STAT_ISSUED;
                    res_entry  = '{seq: issue_seq_reg, tag: '0, len: '0};
                    if (slot_free)
                    begin
                        rsp_load       = 1'b1;
                        issue_seq_next = issue_seq_reg + 1'b1;
                    end
                end
                else if (is_close)
                begin
                    rsp_load = 1'b0;
                end
                else if (is_deliver)
                begin
                    pend_next = in_entry_reg;
                    exp_next  = exp_reg + 1'b1;
                end
                else if (full)
                begin
                    res_status = STAT_DROPPED;
                    rsp_load   = slot_free;
                end
                else
                begin
                    res_status = STAT_HELD;
                    rsp_load   = slot_free;
                    if (slot_free)
                    begin
                        cell_op = CELL_INSERT;
                    end
                end
            end
            S_DRAIN:
            begin
                res_status = STAT_DELIVERED;
                res_entry  = pend_reg;
                res_last   = !found;
                if (slot_free)
                begin
                    rsp_load = 1'b1;
                    if (found)
                    begin
                        cell_op   = CELL_REMOVE;
                        pend_next = found_entry;
                        exp_next  = exp_reg + 1'b1;
                    end
                end
            end
            S_CLOSE:
            begin
                if (occ_vec[0])
                begin
                    res_status = STAT_DISCARDED;
                    res_entry  = cell_slot[0].entry;
                    res_last   = 1'b0;
                    if (slot_free)
                    begin
                        rsp_load = 1'b1;
                        cell_op  = CELL_POP;
                    end
                end
                else
                begin
                    res_status = STAT_CLOSED;
                    res_entry  = '{seq: in_entry_reg.seq, tag: in_entry_reg.tag, len: '0};
                    if (slot_free)
                    begin
                        rsp_load       = 1'b1;
                        issue_seq_next = '0;
                        exp_next       = '0;
                    end
                end
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    assign rsp_valid_next = rsp_load || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_seq_reg <= '0;
            exp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_seq_reg <= issue_seq_next;
            exp_reg       <= exp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_action_reg <= in_action_next;
        in_entry_reg  <= in_entry_next;
        pend_reg      <= pend_next;
        if (rsp_load)
        begin
            rsp_status_reg <= res_status;
            rsp_entry_reg  <= res_entry;
            rsp_last_reg   <= res_last;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = rsp_status_reg;
    assign out_seq   = rsp_entry_reg.seq;
    assign out_tag   = rsp_entry_reg.tag;
    assign out_count = rsp_entry_reg.len;
    assign last      = rsp_last_reg;

    `RCRB_ASSERT_ALWAYS(a_occ_packed, ((occ_vec >> 1) & ~occ_vec) == '0, "occupancy not packed at head")
    `RCRB_ASSERT_IMP(a_no_insert_full, cell_op == CELL_INSERT, !occ_vec[DEPTH-1], "insert into full store")
    `RCRB_ASSERT_NEXT(a_last_to_idle, rsp_load && res_last, state_reg == S_IDLE, "final result without return to idle")
    `RCRB_ASSERT_NEXT(a_close_clears, state_reg == S_CLOSE && slot_free && !occ_vec[0], issue_seq_reg == '0 && exp_reg == '0, "sequences not cleared on close")

endmodule
